// File: src/two_level_lru_cache_hit_classifier_core_defines.svh
// Assertion macros shared by the cache classifier RTL
`ifndef TWO_LEVEL_LRU_CACHE_HIT_CLASSIFIER_CORE_DEFINES_SVH
`define TWO_LEVEL_LRU_CACHE_HIT_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication under reset
`define TLC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define TLC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tlc_pkg.sv
// Shared types and constants of the two-level cache classifier
package tlc_pkg;
    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;
    localparam int CFG_W  = 3;

    typedef enum logic [1:0] {
        CFG_L1_OFF = 2'd0,
        CFG_L1_IDX = 2'd1,
        CFG_L2_OFF = 2'd2,
        CFG_L2_IDX = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_L1_OFF = 3'd2;
    localparam logic [CFG_W-1:0] RST_L1_IDX = 3'd6;
    localparam logic [CFG_W-1:0] RST_L2_OFF = 3'd4;
    localparam logic [CFG_W-1:0] RST_L2_IDX = 3'd3;

    typedef struct packed {
        logic              req;
        logic [ADDR_W-1:0] addr;
        logic [CFG_W-1:0]  off;
        logic [CFG_W-1:0]  ibits;
    } t_lvl_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
    } t_lvl_rsp;
endpackage

// File: src/two_level_lru_cache_hit_classifier_core.sv
// Top level: two-level LRU tag cache hit classifier with hit/miss counters
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_ready  | i_address
//  output  | out       | o_valid / i_ready  | o_l1_hit .. o_l2_miss_count
//  config  | in        | i_cfg_we           | i_cfg_index, i_cfg_data
// L1 hit: S_L1 then S_FIN; L1 miss: S_L1, S_L2, S_FIN (one memory read per level).
// A new address is taken once the sequencer is back in idle with the last one done.
// After reset each level runs a clearing pass over all SETS rows; input waits until
// both levels have cleared. A stalled output holds the result in its register.
`include "two_level_lru_cache_hit_classifier_core_defines.svh"
module two_level_lru_cache_hit_classifier_core #(
    parameter int L1_SETS = 64,
    parameter int L1_WAYS = 4,
    parameter int L2_SETS = 64,
    parameter int L2_WAYS = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [tlc_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [tlc_pkg::ADDR_W-1:0]  i_address,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_l1_hit,
    output logic                        o_l2_accessed,
    output logic                        o_l2_hit,
    output logic [tlc_pkg::CNT_W-1:0]   o_l1_hit_count,
    output logic [tlc_pkg::CNT_W-1:0]   o_l1_miss_count,
    output logic [tlc_pkg::CNT_W-1:0]   o_l2_hit_count,
    output logic [tlc_pkg::CNT_W-1:0]   o_l2_miss_count
);
    import tlc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_L1, S_L2, S_FIN} t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_l1_off, r_l1_idx, r_l2_off, r_l2_idx;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_h1, r_acc, r_h2;
    logic                r_ov, r_o_h1, r_o_acc, r_o_h2;
    logic [CNT_W-1:0]    r_c1h, r_c1m, r_c2h, r_c2m;

    t_lvl_req            l1_req, l2_req;
    t_lvl_rsp            l1_rsp, l2_rsp;
    logic                in_xfer, load;

    assign o_ready = (r_state == S_IDLE) && !l1_rsp.busy && !l2_rsp.busy;
    assign in_xfer = i_valid && o_ready;
    assign load    = (r_state == S_FIN) && (!r_ov || i_ready);

    assign l1_req = '{req: in_xfer, addr: i_address, off: r_l1_off, ibits: r_l1_idx};
    assign l2_req = '{req: (r_state == S_L1) && !l1_rsp.hit, addr: r_addr,
                      off: r_l2_off, ibits: r_l2_idx};

    tlc_level #(.SETS(L1_SETS), .WAYS(L1_WAYS)) u_l1 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (l1_req),
        .o_rsp  (l1_rsp)
    );

    tlc_level #(.SETS(L2_SETS), .WAYS(L2_WAYS)) u_l2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (l2_req),
        .o_rsp  (l2_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_off <= RST_L1_OFF;
            r_l1_idx <= RST_L1_IDX;
            r_l2_off <= RST_L2_OFF;
            r_l2_idx <= RST_L2_IDX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_L1_OFF: r_l1_off <= i_cfg_data;
                CFG_L1_IDX: r_l1_idx <= i_cfg_data;
                CFG_L2_OFF: r_l2_off <= i_cfg_data;
                CFG_L2_IDX: r_l2_idx <= i_cfg_data;
                default:    r_l1_off <= r_l1_off;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_addr <= i_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_h1    <= 1'b0;
            r_acc   <= 1'b0;
            r_h2    <= 1'b0;
            r_ov    <= 1'b0;
            r_o_h1  <= 1'b0;
            r_o_acc <= 1'b0;
            r_o_h2  <= 1'b0;
            r_c1h   <= '0;
            r_c1m   <= '0;
            r_c2h   <= '0;
            r_c2m   <= '0;
        end else begin
            if (r_ov && i_ready && !load) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_L1;
                    end
                end
                S_L1: begin
                    r_h1  <= l1_rsp.hit;
                    r_acc <= !l1_rsp.hit;
                    r_h2  <= 1'b0;
                    r_state <= l1_rsp.hit ? S_FIN : S_L2;
                end
                S_L2: begin
                    r_h2    <= l2_rsp.hit;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (load) begin
                        r_ov    <= 1'b1;
                        r_o_h1  <= r_h1;
                        r_o_acc <= r_acc;
                        r_o_h2  <= r_h2;
                        if (r_h1) begin
                            r_c1h <= r_c1h + CNT_W'(r_c1h != '1);
                        end else begin
                            r_c1m <= r_c1m + CNT_W'(r_c1m != '1);
                            if (r_h2) begin
                                r_c2h <= r_c2h + CNT_W'(r_c2h != '1);
                            end else begin
                                r_c2m <= r_c2m + CNT_W'(r_c2m != '1);
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ov;
    assign o_l1_hit        = r_o_h1;
    assign o_l2_accessed   = r_o_acc;
    assign o_l2_hit        = r_o_h2;
    assign o_l1_hit_count  = r_c1h;
    assign o_l1_miss_count = r_c1m;
    assign o_l2_hit_count  = r_c2h;
    assign o_l2_miss_count = r_c2m;

    `TLC_ASSERT_IMP(a_l2_after_miss, l2_req.req, (r_state == S_L1) && !l1_rsp.hit, "stray L2 req")
    `TLC_ASSERT_IMP(a_h2_needs_acc, (r_state == S_FIN) && r_h2, r_acc && !r_h1, "L2 hit, no lookup")
    `TLC_ASSERT_NXT(a_load_shows, load, r_ov && (r_state == S_IDLE), "result not presented")
endmodule

// File: src/tlc_level.sv
// One set-associative tag level with true LRU, kept in a row-per-set memory
`include "two_level_lru_cache_hit_classifier_core_defines.svh"
module tlc_level #(
    parameter int SETS = 64,
    parameter int WAYS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlc_pkg::t_lvl_req i_req,
    output tlc_pkg::t_lvl_rsp o_rsp
);
    import tlc_pkg::*;

    localparam int SETW   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int IB_MAX = $clog2(SETS + 1) - 1;
    localparam int TAGW   = ADDR_W;
    localparam int ROWW   = WAYS + WAYS * TAGW + WAYS * WW;

    logic [ROWW-1:0] mem [SETS];

    logic                  r_clr;
    logic [SETW-1:0]       r_cnt;
    logic                  r_pend;
    logic [SETW-1:0]       r_set;
    logic [TAGW-1:0]       r_tag;
    logic [ROWW-1:0]       r_row;

    logic [3:0]            ib;
    logic [4:0]            sh;
    logic [ADDR_W-1:0]     set_full;
    logic [SETW-1:0]       n_set;
    logic [TAGW-1:0]       n_tag;

    logic [WAYS-1:0]                 v, nv;
    logic [WAYS-1:0][TAGW-1:0]       t, nt;
    logic [WAYS-1:0][WW-1:0]         o, no, co;
    logic                            hit, inv_f, pos_f;
    logic [WW-1:0]                   hw, iw, sel, p;
    logic [ROWW-1:0]                 new_row, clr_row;

    always_comb begin
        ib       = ({1'b0, i_req.ibits} > 4'(IB_MAX)) ? 4'(IB_MAX) : {1'b0, i_req.ibits};
        sh       = {2'b00, i_req.off} + {1'b0, ib};
        set_full = (i_req.addr >> i_req.off) & ((32'd1 << ib) - 32'd1);
        n_set    = set_full[SETW-1:0];
        n_tag    = i_req.addr >> sh;
    end

    always_comb begin
        v = r_row[WAYS-1:0];
        t = r_row[WAYS+WAYS*TAGW-1:WAYS];
        o = r_row[ROWW-1:WAYS+WAYS*TAGW];
        hit = 1'b0;
        hw = '0;
        inv_f = 1'b0;
        iw = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit && v[w] && t[w] == r_tag) begin
                hit = 1'b1;
                hw  = WW'(w);
            end
            if (!inv_f && !v[w]) begin
                inv_f = 1'b1;
                iw    = WW'(w);
            end
        end
        priority if (hit) begin
            sel = hw;
        end else if (inv_f) begin
            sel = iw;
        end else if (int'(o[0]) >= WAYS) begin
            sel = '0;
        end else begin
            sel = o[0];
        end
        pos_f = 1'b0;
        p = '0;
        for (int q = 0; q < WAYS; q++) begin
            if (!pos_f && o[q] == sel) begin
                pos_f = 1'b1;
                p     = WW'(q);
            end
        end
        for (int q = 0; q < WAYS; q++) begin
            if (!pos_f || WW'(q) < p) begin
                no[q] = o[q];
            end else if (q == WAYS - 1) begin
                no[q] = sel;
            end else begin
                no[q] = o[(q == WAYS - 1) ? q : q + 1];
            end
            co[q] = WW'(q);
        end
        nv = v;
        nt = t;
        if (!hit) begin
            nv[sel] = 1'b1;
            nt[sel] = r_tag;
        end
        new_row = {no, nt, nv};
        clr_row = {co, {(WAYS*TAGW){1'b0}}, {WAYS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            mem[r_cnt] <= clr_row;
        end else if (r_pend) begin
            mem[r_set] <= new_row;
        end
        if (i_req.req) begin
            r_row <= mem[n_set];
            r_set <= n_set;
            r_tag <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= 1'b1;
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_req.req;
            if (r_clr) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SETW'(SETS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.busy = r_clr;
    assign o_rsp.done = r_pend;
    assign o_rsp.hit  = r_pend & hit;

    `TLC_ASSERT_NXT(a_req_then_done, i_req.req, r_pend, "lookup did not complete next cycle")
    `TLC_ASSERT_IMP(a_req_when_free, i_req.req, !r_clr && !r_pend, "lookup while busy")
    `TLC_ASSERT_IMP(a_clear_quiet, r_clr, !r_pend, "lookup during clearing pass")
endmodule

// File: dv/two_level_lru_cache_hit_classifier_core_tb.sv
// Testbench for the two-level LRU tag cache classifier with a predictor
`timescale 1ns / 1ps
module two_level_lru_cache_hit_classifier_core_tb;
    import tlc_pkg::*;

    localparam int SETS = 64;
    localparam int WAYS = 4;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic             l1_hit;
        logic             l2_accessed;
        logic             l2_hit;
        logic [CNT_W-1:0] l1_hits;
        logic [CNT_W-1:0] l1_misses;
        logic [CNT_W-1:0] l2_hits;
        logic [CNT_W-1:0] l2_misses;
    } t_outcome;

    typedef struct {
        bit             is_cfg;
        t_cfg_idx       reg_idx;
        logic [CFG_W-1:0] reg_val;
        logic [ADDR_W-1:0] addr;
    } t_op;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic i_valid, o_ready, o_valid, i_ready;
    logic [ADDR_W-1:0] i_address;
    logic o_l1_hit, o_l2_accessed, o_l2_hit;
    logic [CNT_W-1:0] o_l1_hit_count, o_l1_miss_count, o_l2_hit_count, o_l2_miss_count;

    two_level_lru_cache_hit_classifier_core dut (.*);

    bit              vld [2][SETS*WAYS];
    logic [31:0]     tg  [2][SETS*WAYS];
    int unsigned     ord [2][SETS*WAYS];
    logic [CNT_W-1:0] cnt [4];
    logic [CFG_W-1:0] off_bits [2];
    logic [CFG_W-1:0] idx_bits [2];

    t_op      pending_ops[$];
    t_outcome expected_outcomes[$];
    int       errors;
    int       watchdog;
    bit       stim_done;
    int       tx_wait, rx_wait;
    int       quiet;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void touch(int lv, int base, int w);
        int p;
        p = 0;
        while (p < WAYS && ord[lv][base+p] != w) p++;
        if (p >= WAYS) return;
        for (; p + 1 < WAYS; p++) ord[lv][base+p] = ord[lv][base+p+1];
        ord[lv][base+WAYS-1] = w;
    endfunction

    function automatic bit lookup_fill(int lv, logic [31:0] a);
        int ib, set, base, w;
        logic [31:0] tag;
        ib = 0;
        while (ib < idx_bits[lv] && (2 << ib) <= SETS) ib++;
        set = (a >> off_bits[lv]) & ((1 << ib) - 1);
        tag = a >> (off_bits[lv] + ib);
        base = set * WAYS;
        for (w = 0; w < WAYS; w++)
            if (vld[lv][base+w] && tg[lv][base+w] == tag) begin
                touch(lv, base, w);
                return 1;
            end
        for (w = 0; w < WAYS; w++) if (!vld[lv][base+w]) break;
        if (w >= WAYS) w = ord[lv][base];
        vld[lv][base+w] = 1;
        tg[lv][base+w] = tag;
        touch(lv, base, w);
        return 0;
    endfunction

    function automatic void bump(int i);
        if (cnt[i] != '1) cnt[i]++;
    endfunction

    function automatic t_outcome classify(logic [31:0] a);
        t_outcome r;
        r = '0;
        r.l1_hit = lookup_fill(0, a);
        if (r.l1_hit) bump(0);
        else begin
            bump(1);
            r.l2_accessed = 1;
            r.l2_hit = lookup_fill(1, a);
            bump(r.l2_hit ? 2 : 3);
        end
        r.l1_hits = cnt[0];
        r.l1_misses = cnt[1];
        r.l2_hits = cnt[2];
        r.l2_misses = cnt[3];
        return r;
    endfunction

    task automatic add_cfg(t_cfg_idx idx, int v);
        t_op op;
        op.is_cfg = 1;
        op.reg_idx = idx;
        op.reg_val = CFG_W'(v);
        op.addr = '0;
        pending_ops.push_back(op);
    endtask

    task automatic add_addr(logic [31:0] a);
        t_op op;
        op.is_cfg = 0;
        op.reg_idx = CFG_L1_OFF;
        op.reg_val = '0;
        op.addr = a;
        pending_ops.push_back(op);
    endtask

    initial begin
        int k, phase;
        logic [31:0] pool[16];
        for (k = 0; k < SETS*WAYS; k++) begin
            ord[0][k] = k % WAYS;
            ord[1][k] = k % WAYS;
        end
        off_bits[0] = RST_L1_OFF; idx_bits[0] = RST_L1_IDX;
        off_bits[1] = RST_L2_OFF; idx_bits[1] = RST_L2_IDX;
        foreach (cnt[k]) cnt[k] = '0;
        add_addr(32'h0000_0000);
        add_addr(32'h0000_0000);
        add_addr(32'hFFFF_FFFF);
        add_addr(32'hFFFF_FFFF);
        add_addr(32'h0000_0003);
        add_addr(32'h0000_0010);
        for (k = 0; k < 6; k++) add_addr(k << 8);
        for (k = 0; k < 6; k++) add_addr(k << 8);
        add_cfg(CFG_L1_OFF, 7); add_cfg(CFG_L1_IDX, 7);
        add_cfg(CFG_L2_OFF, 0); add_cfg(CFG_L2_IDX, 0);
        add_addr(32'h8000_0000); add_addr(32'h7FFF_FFFF); add_addr(32'h8000_0001);
        add_cfg(CFG_L1_OFF, 0); add_cfg(CFG_L1_IDX, 0);
        add_cfg(CFG_L2_OFF, 7); add_cfg(CFG_L2_IDX, 6);
        add_addr(32'h5555_5555); add_addr(32'hAAAA_AAAA); add_addr(32'h5555_5555);
        for (phase = 0; phase < 8; phase++) begin
            add_cfg(CFG_L1_OFF, $urandom_range(0, 7));
            add_cfg(CFG_L1_IDX, $urandom_range(0, 7));
            add_cfg(CFG_L2_OFF, $urandom_range(0, 7));
            add_cfg(CFG_L2_IDX, $urandom_range(0, 7));
            foreach (pool[k]) pool[k] = $urandom();
            for (k = 0; k < 250; k++) begin
                if ($urandom_range(0, 9) < 2) add_addr($urandom());
                else add_addr(pool[$urandom_range(0, 15)] ^ $urandom_range(0, 255));
            end
        end
        stim_done = 1;
    end

    always @(posedge i_clk) begin
        bit cfg_go;
        cfg_go = 0;
        if (!i_rst_n) begin
            i_valid <= 0;
            tx_wait <= 0;
            quiet <= 0;
        end else begin
            if (i_valid && o_ready) begin
                i_valid <= 0;
                tx_wait <= $urandom_range(0, 3);
            end else if (!i_valid) begin
                if (tx_wait > 0) tx_wait <= tx_wait - 1;
                else if (pending_ops.size() > 0) begin
                    if (pending_ops[0].is_cfg) begin
                        if (expected_outcomes.size() == 0 && quiet >= 8) begin
                            cfg_go = 1;
                            i_cfg_index <= pending_ops[0].reg_idx;
                            i_cfg_data <= pending_ops[0].reg_val;
                            if (pending_ops[0].reg_idx inside {CFG_L1_OFF, CFG_L1_IDX})
                                if (pending_ops[0].reg_idx == CFG_L1_OFF)
                                    off_bits[0] = pending_ops[0].reg_val;
                                else idx_bits[0] = pending_ops[0].reg_val;
                            else if (pending_ops[0].reg_idx == CFG_L2_OFF)
                                off_bits[1] = pending_ops[0].reg_val;
                            else idx_bits[1] = pending_ops[0].reg_val;
                            void'(pending_ops.pop_front());
                        end
                    end else begin
                        i_valid <= 1;
                        i_address <= pending_ops[0].addr;
                        expected_outcomes.push_back(classify(pending_ops[0].addr));
                        void'(pending_ops.pop_front());
                    end
                end
            end
            if (expected_outcomes.size() == 0 && !i_valid) quiet <= quiet + 1;
            else quiet <= 0;
        end
        i_cfg_we <= cfg_go;
    end

    always @(posedge i_clk) begin
        t_outcome exp_r;
        if (!i_rst_n) begin
            i_ready <= 0;
            rx_wait <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end else begin
                    exp_r = expected_outcomes.pop_front();
                    if (o_l1_hit !== exp_r.l1_hit) begin
                        $error("l1_hit exp %0d got %0d", exp_r.l1_hit, o_l1_hit); errors++;
                    end
                    if (o_l2_accessed !== exp_r.l2_accessed) begin
                        $error("l2_accessed exp %0d got %0d", exp_r.l2_accessed, o_l2_accessed);
                        errors++;
                    end
                    if (o_l2_hit !== exp_r.l2_hit) begin
                        $error("l2_hit exp %0d got %0d", exp_r.l2_hit, o_l2_hit); errors++;
                    end
                    if (o_l1_hit_count !== exp_r.l1_hits) begin
                        $error("l1_hit_count exp %0d got %0d", exp_r.l1_hits, o_l1_hit_count);
                        errors++;
                    end
                    if (o_l1_miss_count !== exp_r.l1_misses) begin
                        $error("l1_miss_count exp %0d got %0d", exp_r.l1_misses,
                               o_l1_miss_count);
                        errors++;
                    end
                    if (o_l2_hit_count !== exp_r.l2_hits) begin
                        $error("l2_hit_count exp %0d got %0d", exp_r.l2_hits, o_l2_hit_count);
                        errors++;
                    end
                    if (o_l2_miss_count !== exp_r.l2_misses) begin
                        $error("l2_miss_count exp %0d got %0d", exp_r.l2_misses,
                               o_l2_miss_count);
                        errors++;
                    end
                end
                i_ready <= 0;
                rx_wait <= $urandom_range(0, 3);
            end else if (!i_ready) begin
                if (rx_wait > 0) rx_wait <= rx_wait - 1;
                else i_ready <= 1;
            end
        end
    end

    initial begin
        errors = 0;
        watchdog = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_address = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        while (!(stim_done && pending_ops.size() == 0 && !i_valid &&
                 expected_outcomes.size() == 0)) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) watchdog = 0;
            else watchdog++;
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: two_level_lru_cache_hit_classifier_core.f
+incdir+src
src/tlc_pkg.sv
src/tlc_level.sv
src/two_level_lru_cache_hit_classifier_core.sv
dv/two_level_lru_cache_hit_classifier_core_tb.sv
